FILE: hdl/adcma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcma_pkg
// Shared sizes and types for the moving-average core: window depth, sum
// and count widths, and the job handed from the front end to the divider.
// ----------------------------------------------------------------------------
package adcma_pkg;

    localparam int DEPTH      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int AVG_W      = 16;
    localparam int FILL_W     = 5;
    localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int SUM_W      = SAMPLE_W + $clog2(DEPTH);
    localparam int STEP_W     = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } avg_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

FILE: hdl/adc_moving_average_core.sv
`timescale 1ns / 1ps
// flow: a sample beat is registered, its sum/count job is pushed to the queue,
// and the shift-subtract divider pops it, forms one quotient bit per cycle and
// loads the output register; neither front end nor divider takes new work mid-job
// a two-entry job queue and the output register let input and output stall apart
// reset: synchronous active-low aresetn clears position, fill count, sum and
// queue; ring contents are not cleared and are read only once written
// ----------------------------------------------------------------------------
// adc_moving_average_core
// Boxcar moving average over converter samples: ring front end, job queue
// and iterative divider giving the truncated mean and fill count.
// ----------------------------------------------------------------------------
module adc_moving_average_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [adcma_pkg::SAMPLE_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [adcma_pkg::AVG_W-1:0]   m_average,
    output logic [adcma_pkg::FILL_W-1:0]  m_fill_count
);

    adcma_pkg::fifo_status_t  q_status;
    adcma_pkg::avg_job_t      push_job;
    adcma_pkg::avg_job_t      pop_job;
    logic                     q_push;
    logic                     q_pop;

    adcma_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .q_status (q_status),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    adcma_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    adcma_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_average    (m_average),
        .m_fill_count (m_fill_count)
    );

    // queue never pushed while full
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_status.full)
        else $error("job queue overflow");

    // divider never starts on an empty window
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (pop_job.count != '0))
        else $error("zero divisor popped");

    // front end takes one sample at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sample beat accepted during update");

    // reported fill count stays within the window
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_fill_count != '0 &&
                     m_fill_count <= adcma_pkg::FILL_W'(adcma_pkg::DEPTH)))
        else $error("fill count out of range");

endmodule

FILE: hdl/adcma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcma_front
// Accepts samples, keeps the sample ring, write position, fill count and
// running sum, and pushes one sum/count job per sample into the queue.
// ----------------------------------------------------------------------------
module adcma_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [adcma_pkg::SAMPLE_W-1:0] s_sample,
    input  adcma_pkg::fifo_status_t       q_status,
    output logic                          q_push,
    output adcma_pkg::avg_job_t           q_job
);

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } front_state_t;

    front_state_t                    state_reg;
    logic [adcma_pkg::SAMPLE_W-1:0]  ring [adcma_pkg::DEPTH];
    logic [adcma_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [adcma_pkg::SAMPLE_W-1:0]  old_reg;
    logic [adcma_pkg::PTR_W-1:0]     pos_reg;
    logic [adcma_pkg::CNT_W-1:0]     count_reg;
    logic [adcma_pkg::SUM_W-1:0]     sum_reg;
    logic [adcma_pkg::SUM_W-1:0]     sum_next;
    logic [adcma_pkg::CNT_W-1:0]     count_next;
    logic [adcma_pkg::PTR_W-1:0]     pos_next;
    logic                            full;

    assign s_ready = (state_reg == ST_IDLE) && !q_status.full;
    assign full    = (count_reg == adcma_pkg::CNT_W'(adcma_pkg::DEPTH));

    always_comb begin
        sum_next = sum_reg + adcma_pkg::SUM_W'(sample_reg);
        if (full) begin
            sum_next = sum_next - adcma_pkg::SUM_W'(old_reg);
        end
        count_next = full ? count_reg : count_reg + 1'b1;
        if (pos_reg == adcma_pkg::PTR_W'(adcma_pkg::DEPTH - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + 1'b1;
        end
    end

    assign q_push      = (state_reg == ST_CALC);
    assign q_job.sum   = sum_next;
    assign q_job.count = count_next;

    // ring storage, read port always tracks the write position
    always_ff @(posedge aclk) begin
        old_reg <= ring[pos_reg];
        if (state_reg == ST_CALC) begin
            ring[pos_reg] <= sample_reg;
        end
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        state_reg <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    sum_reg   <= sum_next;
                    count_reg <= count_next;
                    pos_reg   <= pos_next;
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/adcma_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcma_fifo
// Two-entry job queue between the front end and the divider.
// ----------------------------------------------------------------------------
module adcma_fifo (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  adcma_pkg::avg_job_t      push_job,
    input  logic                     pop,
    output adcma_pkg::avg_job_t      pop_job,
    output adcma_pkg::fifo_status_t  status
);

    adcma_pkg::avg_job_t                  mem [adcma_pkg::FIFO_DEPTH];
    logic [adcma_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg;
    logic [adcma_pkg::FIFO_PTR_W-1:0]     rd_ptr_reg;
    logic [adcma_pkg::FIFO_CNT_W-1:0]     cnt_reg;
    logic                                 do_push;
    logic                                 do_pop;

    assign status.full  = (cnt_reg == adcma_pkg::FIFO_CNT_W'(adcma_pkg::FIFO_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_job      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

FILE: hdl/adcma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adcma_div
// Back end: pops a job, divides the sum by the fill count one quotient bit
// per cycle, and holds the result in the output register.
// ----------------------------------------------------------------------------
module adcma_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  adcma_pkg::fifo_status_t       q_status,
    input  adcma_pkg::avg_job_t           q_job,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [adcma_pkg::AVG_W-1:0]   m_average,
    output logic [adcma_pkg::FILL_W-1:0]  m_fill_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } div_state_t;

    div_state_t                     state_reg;
    logic [adcma_pkg::SUM_W-1:0]    quo_reg;
    logic [adcma_pkg::CNT_W-1:0]    rem_reg;
    logic [adcma_pkg::CNT_W-1:0]    div_reg;
    logic [adcma_pkg::STEP_W-1:0]   step_reg;
    logic                           m_valid_reg;
    logic [adcma_pkg::AVG_W-1:0]    avg_reg;
    logic [adcma_pkg::FILL_W-1:0]   fill_reg;
    logic [adcma_pkg::CNT_W:0]      shifted;
    logic                           ge;
    logic [adcma_pkg::CNT_W:0]      diff;
    logic                           out_free;

    assign q_pop        = (state_reg == ST_IDLE) && !q_status.empty;
    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_average    = avg_reg;
    assign m_fill_count = fill_reg;

    always_comb begin
        shifted = {rem_reg, quo_reg[adcma_pkg::SUM_W-1]};
        ge      = (shifted >= {1'b0, div_reg});
        diff    = shifted - {1'b0, div_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
        end else begin
            if ((state_reg == ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_pop) begin
                        quo_reg   <= q_job.sum;
                        div_reg   <= q_job.count;
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= ge ? diff[adcma_pkg::CNT_W-1:0]
                                   : shifted[adcma_pkg::CNT_W-1:0];
                    quo_reg  <= {quo_reg[adcma_pkg::SUM_W-2:0], ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == adcma_pkg::STEP_W'(adcma_pkg::SUM_W - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        avg_reg     <= quo_reg[adcma_pkg::AVG_W-1:0];
                        fill_reg    <= adcma_pkg::FILL_W'(div_reg);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
